// ----- design/gf_vandermonde_rs_encoder_top_macros.svh -----
// Assertion helpers for the encoder checker
`ifndef GF_VANDERMONDE_RS_ENCODER_TOP_MACROS_SVH
`define GF_VANDERMONDE_RS_ENCODER_TOP_MACROS_SVH

// Check cons in the same cycle as ante
`define GVRE_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gvre check failed");

// Check cons in the cycle after ante
`define GVRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gvre check failed");

`endif

// ----- design/gvre_pkg.sv -----
`default_nettype none

package gvre_pkg;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StEval = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    RegFieldPoly = 2'd0,
    RegDataCount = 2'd1,
    RegCodeCount = 2'd2
  } reg_idx_e;

  localparam int CfgW = 7;
  localparam logic [8:0] FieldPolyRst = 9'd283;
  localparam logic [CfgW-1:0] DataCountRst = 7'd16;
  localparam logic [CfgW-1:0] CodeCountRst = 7'd32;

  // default reduction polynomial for a given symbol width
  function automatic logic [15:0] default_poly(input logic [3:0] width);
    logic [15:0] res;
    case (width)
      4'd1:    res = 16'h0003;
      4'd2:    res = 16'h0007;
      4'd3:    res = 16'h000b;
      4'd4:    res = 16'h0013;
      4'd5:    res = 16'h0025;
      4'd6:    res = 16'h0043;
      4'd7:    res = 16'h0083;
      4'd8:    res = 16'h011b;
      4'd9:    res = 16'h0203;
      4'd10:   res = 16'h0409;
      4'd11:   res = 16'h0805;
      4'd12:   res = 16'h1009;
      4'd13:   res = 16'h201b;
      4'd14:   res = 16'h4021;
      4'd15:   res = 16'h8003;
      default: res = 16'h0000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- design/gf_vandermonde_rs_encoder_top.sv -----
// Load: one message symbol per cycle while busy is low; the block starts
// at the transfer of the data_count-th symbol.
// Code symbol k is the message polynomial evaluated at point k, registered behind the message store read port.
// Throughput: one Horner step per cycle over the message store read port; no new block is loaded while busy.
// The receiver cannot stall; each result is shown for one cycle.
// Reset returns the configuration registers to their defaults and drops any partly loaded block.
`default_nettype none

module gf_vandermonde_rs_encoder_top
  import gvre_pkg::*;
#(
  parameter int SYMBOL_BITS = 8,
  parameter int MAX_DATA    = 64,
  parameter int MAX_CODE    = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  data_symbol_i,
  output logic             code_valid_o,
  output logic [7:0]       code_symbol_o,
  output logic [5:0]       code_index_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SB = SYMBOL_BITS;
  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  function automatic logic [SB-1:0] gf_mul(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                           input logic [SB:0] p);
    logic [2*SB-2:0] prod;
    prod = '0;
    for (int k = 0; k < SB; k++) begin
      if (a[k]) prod = prod ^ ((2*SB-1)'(b) << k);
    end
    for (int k = 2*SB-2; k >= SB; k--) begin
      if (prod[k]) prod = prod ^ ((2*SB-1)'(p) << (k - SB));
    end
    return prod[SB-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [8:0]      field_poly_q;
  logic [CfgW-1:0] data_count_q, code_count_q;
  logic [CfgW-1:0] load_q, j_q, i_q;
  logic [CfgW-1:0] d_eff, c_eff;
  logic [SB:0]     poly_eff;
  logic [SB-1:0]   poly_low;

  logic            cfg_wr, accept, eval;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SB-1:0]   ram_wdata, ram_rdata;

  logic            vld_q, first_q, fin_q, lst_q;
  logic [SB-1:0]   pt_q, acc_q, nxt;
  logic [5:0]      idx_q;
  logic            code_valid_q, last_q;
  logic [7:0]      code_symbol_q;
  logic [5:0]      code_index_q;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = (state_q == StEval);
  assign eval   = (state_q == StEval);
  assign accept = start && !busy;

  always_comb begin
    d_eff = (data_count_q == '0) ? 7'd1 : data_count_q;
    if ({2'b00, d_eff} > 9'(MAX_DATA)) d_eff = 7'(MAX_DATA);
    c_eff = (code_count_q == '0) ? 7'd1 : code_count_q;
    if ({2'b00, c_eff} > 9'(MAX_CODE)) c_eff = 7'(MAX_CODE);
    if (c_eff < d_eff) c_eff = d_eff;
    if ({2'b00, c_eff} > 9'(MAX_CODE)) c_eff = 7'(MAX_CODE);
  end

  assign poly_low = (field_poly_q == '0) ? SB'(default_poly(4'(SB))) : SB'(field_poly_q);
  assign poly_eff = {1'b1, poly_low};

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      RegFieldPoly: prdata = 32'(field_poly_q);
      RegDataCount: prdata = 32'(data_count_q);
      RegCodeCount: prdata = 32'(code_count_q);
      default:      prdata = '0;
    endcase
  end

  assign ram_we    = accept;
  assign ram_waddr = AW'(load_q);
  assign ram_wdata = SB'(data_symbol_i);
  assign ram_raddr = AW'(j_q);

  gvre_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_DATA)
  ) u_msg_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: if (accept && !cfg_wr && (load_q + 7'd1 >= d_eff)) state_d = StEval;
      StEval: if (j_q == '0 && i_q == c_eff - 7'd1) state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      field_poly_q <= FieldPolyRst;
      data_count_q <= DataCountRst;
      code_count_q <= CodeCountRst;
      load_q       <= '0;
      j_q          <= '0;
      i_q          <= '0;
      vld_q        <= 1'b0;
      code_valid_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= eval;
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[3:2]))
          RegFieldPoly: field_poly_q <= pwdata[8:0];
          RegDataCount: data_count_q <= pwdata[CfgW-1:0];
          RegCodeCount: code_count_q <= pwdata[CfgW-1:0];
          default: ;
        endcase
        if (paddr[3:2] != 2'd3) load_q <= '0;
      end else if (accept) begin
        if (load_q + 7'd1 >= d_eff) begin
          load_q <= '0;
          j_q    <= d_eff - 7'd1;
          i_q    <= '0;
        end else begin
          load_q <= load_q + 7'd1;
        end
      end
      if (eval) begin
        if (j_q == '0) begin
          j_q <= d_eff - 7'd1;
          i_q <= i_q + 7'd1;
        end else begin
          j_q <= j_q - 7'd1;
        end
      end
      code_valid_q <= vld_q && fin_q;
      last_q       <= vld_q && fin_q && lst_q;
    end
  end

  assign nxt = gf_mul(first_q ? '0 : acc_q, pt_q, poly_eff) ^ ram_rdata;

  always_ff @(posedge clk_i) begin
    first_q <= (j_q == d_eff - 7'd1);
    fin_q   <= (j_q == '0);
    lst_q   <= (i_q == c_eff - 7'd1);
    pt_q    <= SB'(i_q);
    idx_q   <= i_q[5:0];
    if (vld_q) begin
      acc_q <= nxt;
    end
    if (vld_q && fin_q) begin
      code_symbol_q <= 8'(nxt);
      code_index_q  <= idx_q;
    end
  end

  assign code_valid_o  = code_valid_q;
  assign code_symbol_o = code_symbol_q;
  assign code_index_o  = code_index_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ----- design/gvre_ram.sv -----
`default_nettype none

module gvre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/gvre_checker.sv -----
`default_nettype none

`include "gf_vandermonde_rs_encoder_top_macros.svh"

module gvre_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic pready,
  input wire logic psel,
  input wire logic penable,
  input wire logic code_valid_o,
  input wire logic last_o
);

  `GVRE_ASSERT(a_pready_access, clk_i, rst_ni, psel && penable, pready)
  `GVRE_ASSERT(a_last_with_valid, clk_i, rst_ni, last_o, code_valid_o)
  `GVRE_ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, code_valid_o && last_o, !code_valid_o)

endmodule

bind gf_vandermonde_rs_encoder_top gvre_checker u_gvre_checker (.*);

`default_nettype wire
